/* design/icmp4_ctx_pkg.sv */
// ----------------------------------------------------------------------------
// icmp4_ctx_pkg
// Types, constants and helpers for the quoted IPv4 header parser.
// ----------------------------------------------------------------------------
package icmp4_ctx_pkg;

  localparam int unsigned CountW      = 7;
  localparam int unsigned HdrW        = 6;
  localparam logic [CountW-1:0] CountMax    = 7'd127;
  localparam logic [CountW-1:0] MinHdrBytes = 7'd20;
  localparam logic [CountW-1:0] PortBytes   = 7'd4;

  localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;
  localparam logic [7:0] PROTO_NUM_TCP  = 8'd6;
  localparam logic [7:0] PROTO_NUM_UDP  = 8'd17;

  localparam logic [15:0] SUM_GOOD = 16'hffff;

  // icmp message types with a request/reply counterpart
  localparam logic [7:0] MSG_ECHO_REP   = 8'd0;
  localparam logic [7:0] MSG_ECHO_REQ   = 8'd8;
  localparam logic [7:0] MSG_ROUTER_ADV = 8'd9;
  localparam logic [7:0] MSG_ROUTER_SOL = 8'd10;
  localparam logic [7:0] MSG_TS_REQ     = 8'd13;
  localparam logic [7:0] MSG_TS_REP     = 8'd14;
  localparam logic [7:0] MSG_INFO_REQ   = 8'd15;
  localparam logic [7:0] MSG_INFO_REP   = 8'd16;
  localparam logic [7:0] MSG_MASK_REQ   = 8'd17;
  localparam logic [7:0] MSG_MASK_REP   = 8'd18;

  typedef enum logic [1:0] {
    PROTO_UNKNOWN = 2'd0,
    PROTO_TCP     = 2'd1,
    PROTO_UDP     = 2'd2,
    PROTO_ICMP    = 2'd3
  } proto_class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0]  source_address;
    logic [31:0]  dest_address;
    logic [15:0]  source_port;
    logic [15:0]  dest_port;
    logic [15:0]  total_length;
    proto_class_t proto_class;
    logic [12:0]  fragment_offset;
    logic         more_fragments;
    logic         dont_fragment;
    logic         header_length_bad;
    logic         checksum_bad;
  } out_item_t;

  // per-packet parse context
  typedef struct packed {
    logic [CountW-1:0] byte_count;
    logic [HdrW-1:0]   header_bytes;
    logic [15:0]       sum_accumulator;
    logic [7:0]        high_byte_hold;
    logic [15:0]       length_word;
    logic [15:0]       fragment_word;
    logic [7:0]        protocol_byte;
    logic [31:0]       source_word;
    logic [31:0]       dest_word;
    logic [31:0]       port_bytes;
  } pkt_ctx_t;

  function automatic logic [7:0] counterpart_type(input logic [7:0] t, input logic [7:0] code);
    logic [7:0] r;
    case (t)
      MSG_ECHO_REQ:   r = MSG_ECHO_REP;
      MSG_ECHO_REP:   r = MSG_ECHO_REQ;
      MSG_TS_REQ:     r = MSG_TS_REP;
      MSG_TS_REP:     r = MSG_TS_REQ;
      MSG_INFO_REQ:   r = MSG_INFO_REP;
      MSG_INFO_REP:   r = MSG_INFO_REQ;
      MSG_ROUTER_SOL: r = MSG_ROUTER_ADV;
      MSG_MASK_REQ:   r = MSG_MASK_REP;
      MSG_MASK_REP:   r = MSG_MASK_REQ;
      default:        r = code;
    endcase
    return r;
  endfunction

endpackage

/* design/icmp4_ctx_capture.sv */
// ----------------------------------------------------------------------------
// icmp4_ctx_capture
// Per-byte update of the parse context: count, header fields, checksum, ports.
// ----------------------------------------------------------------------------
module icmp4_ctx_capture import icmp4_ctx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output pkt_ctx_t ctx_upd
);

  pkt_ctx_t ctx_r;
  pkt_ctx_t ctx_nxt;

  logic [CountW-1:0] idx;
  logic [CountW-1:0] hdr_len;
  logic [CountW-1:0] port_off;
  logic [16:0]       sum_raw;
  logic [7:0]        b;

  always_comb begin
    b       = item.data_byte;
    idx     = ctx_r.byte_count;
    ctx_upd = ctx_r;

    if (idx == '0) begin
      ctx_upd.header_bytes = {b[3:0], 2'b00};
    end
    hdr_len  = {1'b0, ctx_upd.header_bytes};
    port_off = idx - hdr_len;
    sum_raw  = {1'b0, ctx_r.sum_accumulator} + {1'b0, ctx_r.high_byte_hold, b};

    case (idx)
      7'd2:  ctx_upd.length_word[15:8]   = b;
      7'd3:  ctx_upd.length_word[7:0]    = b;
      7'd6:  ctx_upd.fragment_word[15:8] = b;
      7'd7:  ctx_upd.fragment_word[7:0]  = b;
      7'd9:  ctx_upd.protocol_byte       = b;
      7'd12: ctx_upd.source_word[31:24]  = b;
      7'd13: ctx_upd.source_word[23:16]  = b;
      7'd14: ctx_upd.source_word[15:8]   = b;
      7'd15: ctx_upd.source_word[7:0]    = b;
      7'd16: ctx_upd.dest_word[31:24]    = b;
      7'd17: ctx_upd.dest_word[23:16]    = b;
      7'd18: ctx_upd.dest_word[15:8]     = b;
      7'd19: ctx_upd.dest_word[7:0]      = b;
      default: ;
    endcase

    if (idx < hdr_len) begin
      if (!idx[0]) begin
        ctx_upd.high_byte_hold = b;
      end else begin
        // end-around carry keeps the sum within 16 bits
        ctx_upd.sum_accumulator = sum_raw[15:0] + {15'd0, sum_raw[16]};
      end
    end else if (idx < hdr_len + PortBytes) begin
      case (port_off[1:0])
        2'd0:    ctx_upd.port_bytes[31:24] = b;
        2'd1:    ctx_upd.port_bytes[23:16] = b;
        2'd2:    ctx_upd.port_bytes[15:8]  = b;
        default: ctx_upd.port_bytes[7:0]   = b;
      endcase
    end

    if (idx < CountMax) begin
      ctx_upd.byte_count = idx + 7'd1;
    end
  end

  always_comb begin
    ctx_nxt = ctx_r;
    if (accept) begin
      ctx_nxt = item.last_byte ? '0 : ctx_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
    end else begin
      ctx_r <= ctx_nxt;
    end
  end

endmodule

/* design/icmp4_ctx_format.sv */
// ----------------------------------------------------------------------------
// icmp4_ctx_format
// Builds the result item from the parse context of the final byte.
// ----------------------------------------------------------------------------
module icmp4_ctx_format import icmp4_ctx_pkg::*; (
  input  pkt_ctx_t  ctx,
  output out_item_t res
);

  logic [CountW-1:0] len;
  logic [CountW-1:0] hdr_len;

  always_comb begin
    len     = ctx.byte_count;
    hdr_len = {1'b0, ctx.header_bytes};
    res     = '0;

    if (hdr_len < MinHdrBytes || hdr_len > len) begin
      res.header_length_bad = 1'b1;
    end else begin
      res.source_address  = ctx.source_word;
      res.dest_address    = ctx.dest_word;
      res.total_length    = ctx.length_word;
      res.checksum_bad    = ctx.sum_accumulator != SUM_GOOD;
      res.fragment_offset = ctx.fragment_word[12:0];
      res.more_fragments  = ctx.fragment_word[13];
      res.dont_fragment   = ctx.fragment_word[14];
      case (ctx.protocol_byte)
        PROTO_NUM_TCP:  res.proto_class = PROTO_TCP;
        PROTO_NUM_UDP:  res.proto_class = PROTO_UDP;
        PROTO_NUM_ICMP: res.proto_class = PROTO_ICMP;
        default:        res.proto_class = PROTO_UNKNOWN;
      endcase
      if (len < hdr_len + PortBytes) begin
        res.header_length_bad = 1'b1;
      end else if (res.proto_class == PROTO_TCP || res.proto_class == PROTO_UDP) begin
        res.source_port = ctx.port_bytes[31:16];
        res.dest_port   = ctx.port_bytes[15:0];
      end else if (res.proto_class == PROTO_ICMP) begin
        res.source_port = {8'd0, ctx.port_bytes[31:24]};
        res.dest_port   = {8'd0, counterpart_type(ctx.port_bytes[31:24],
                                                  ctx.port_bytes[23:16])};
      end
    end
  end

endmodule

/* design/icmp4_error_context_parser_core.sv */
// ----------------------------------------------------------------------------
// icmp4_error_context_parser_core
// Parses the IPv4 packet quoted in an ICMP error, one byte per transaction.
//
//   channel  direction  payload     handshake
//   in_      input      in_item_t   in_valid / in_stall
//   out_     output     out_item_t  out_valid / out_stall
//
// one byte is taken every cycle while in_stall is low; the result of a packet
// appears in the output register the cycle after its last byte is accepted
// reset (synchronous, rst_n low) clears the parse context and the output valid flag
// in_stall is high only while a result waits in the output register and
// out_stall holds it; the register is reloaded as it drains
// ----------------------------------------------------------------------------
module icmp4_error_context_parser_core import icmp4_ctx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      in_accept;
  pkt_ctx_t  ctx_upd;
  out_item_t res;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;
  out_item_t out_data_nxt;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  icmp4_ctx_capture u_capture (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .item    (in_data),
    .ctx_upd (ctx_upd)
  );

  icmp4_ctx_format u_format (
    .ctx (ctx_upd),
    .res (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (in_accept && in_data.last_byte) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/icmp4_ctx_checker.sv */
// ----------------------------------------------------------------------------
// icmp4_ctx_checker
// Port-level checks on the quoted IPv4 header parser.
// ----------------------------------------------------------------------------
module icmp4_ctx_checker import icmp4_ctx_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // the input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // an accepted last byte gives a result next cycle
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_byte |=> out_valid)
    else $error("no result after last byte");

  // ports only for a complete tcp, udp or icmp header
  a_ports_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.header_length_bad || out_data.proto_class == PROTO_UNKNOWN)
    |-> out_data.source_port == 16'd0 && out_data.dest_port == 16'd0)
    else $error("ports given without a valid header");

endmodule

bind icmp4_error_context_parser_core icmp4_ctx_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quoted IPv4 header parser. A short table of
// directed bytes comes first, then randomly built quoted packets. Most are
// well formed with a correct header checksum; the rest are truncated, have a
// short IHL, carry a corrupted checksum or run past the byte counter. Each
// accepted byte feeds a bench-side parser, whose results are queued and
// compared field by field with what the block returns. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import icmp4_ctx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBytes = 1950;
  localparam int unsigned CycleLimit  = 120000;
  localparam int unsigned DrainCycles = 8;

  localparam out_item_t NoCheck   = '{proto_class: PROTO_UNKNOWN, default: '0};
  localparam out_item_t BadHeader = '{proto_class: PROTO_UNKNOWN, header_length_bad: 1'b1,
                                      default: '0};

  typedef struct packed {
    in_item_t  item;
    logic      has_want;
    out_item_t want;
  } directed_row_t;

  // single-byte packets first, then an icmp echo quote with extreme fields
  localparam directed_row_t DirectedRows [26] = '{
    '{'{8'h00, 1'b1}, 1'b1, BadHeader},
    '{'{8'hff, 1'b1}, 1'b1, BadHeader},
    '{'{8'h45, 1'b0}, 1'b0, NoCheck},
    '{'{8'h00, 1'b0}, 1'b0, NoCheck},
    '{'{8'h00, 1'b0}, 1'b0, NoCheck},
    '{'{8'h1c, 1'b0}, 1'b0, NoCheck},
    '{'{8'hab, 1'b0}, 1'b0, NoCheck},
    '{'{8'hcd, 1'b0}, 1'b0, NoCheck},
    '{'{8'h7f, 1'b0}, 1'b0, NoCheck},
    '{'{8'hff, 1'b0}, 1'b0, NoCheck},
    '{'{8'h40, 1'b0}, 1'b0, NoCheck},
    '{'{8'h01, 1'b0}, 1'b0, NoCheck},
    '{'{8'h00, 1'b0}, 1'b0, NoCheck},
    '{'{8'h00, 1'b0}, 1'b0, NoCheck},
    '{'{8'hff, 1'b0}, 1'b0, NoCheck},
    '{'{8'hff, 1'b0}, 1'b0, NoCheck},
    '{'{8'hff, 1'b0}, 1'b0, NoCheck},
    '{'{8'hff, 1'b0}, 1'b0, NoCheck},
    '{'{8'h00, 1'b0}, 1'b0, NoCheck},
    '{'{8'h00, 1'b0}, 1'b0, NoCheck},
    '{'{8'h00, 1'b0}, 1'b0, NoCheck},
    '{'{8'h00, 1'b0}, 1'b0, NoCheck},
    '{'{8'h08, 1'b0}, 1'b0, NoCheck},
    '{'{8'h00, 1'b0}, 1'b0, NoCheck},
    '{'{8'h12, 1'b0}, 1'b0, NoCheck},
    '{'{8'h34, 1'b1}, 1'b0, NoCheck}
  };

  localparam logic [7:0] IcmpTypes [10] = '{
    MSG_ECHO_REP, MSG_ECHO_REQ, MSG_ROUTER_ADV, MSG_ROUTER_SOL, MSG_TS_REQ,
    MSG_TS_REP, MSG_INFO_REQ, MSG_INFO_REP, MSG_MASK_REQ, MSG_MASK_REP
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  bit          calm = 1'b0;
  out_item_t   awaited_results [$];
  out_item_t   oldest_result;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned bytes_sent     = 0;
  int unsigned packets_built  = 0;
  int unsigned results_seen   = 0;
  int unsigned tcp_seen = 0, udp_seen = 0, icmp_seen = 0;
  int unsigned bad_len_seen = 0, bad_sum_seen = 0;

  // bench-side parse context
  logic [6:0]  ctx_count;
  logic [5:0]  ctx_hdr_bytes;
  logic [16:0] ctx_sum;
  logic [7:0]  ctx_hold;
  logic [15:0] ctx_length;
  logic [15:0] ctx_frag;
  logic [7:0]  ctx_proto;
  logic [31:0] ctx_src;
  logic [31:0] ctx_dst;
  logic [31:0] ctx_ports;

  icmp4_error_context_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] result %0d: %s got 0x%0h want 0x%0h", $realtime, results_seen, what,
             got, want);
    mismatch_count++;
  endtask

  task automatic compare_result(input out_item_t got, input out_item_t want);
    if (got.source_address !== want.source_address)
      report_mismatch("source_address", got.source_address, want.source_address);
    if (got.dest_address !== want.dest_address)
      report_mismatch("dest_address", got.dest_address, want.dest_address);
    if (got.source_port !== want.source_port)
      report_mismatch("source_port", 32'(got.source_port), 32'(want.source_port));
    if (got.dest_port !== want.dest_port)
      report_mismatch("dest_port", 32'(got.dest_port), 32'(want.dest_port));
    if (got.total_length !== want.total_length)
      report_mismatch("total_length", 32'(got.total_length), 32'(want.total_length));
    if (got.proto_class !== want.proto_class)
      report_mismatch("proto_class", 32'(got.proto_class), 32'(want.proto_class));
    if (got.fragment_offset !== want.fragment_offset)
      report_mismatch("fragment_offset", 32'(got.fragment_offset),
                      32'(want.fragment_offset));
    if (got.more_fragments !== want.more_fragments)
      report_mismatch("more_fragments", 32'(got.more_fragments), 32'(want.more_fragments));
    if (got.dont_fragment !== want.dont_fragment)
      report_mismatch("dont_fragment", 32'(got.dont_fragment), 32'(want.dont_fragment));
    if (got.header_length_bad !== want.header_length_bad)
      report_mismatch("header_length_bad", 32'(got.header_length_bad),
                      32'(want.header_length_bad));
    if (got.checksum_bad !== want.checksum_bad)
      report_mismatch("checksum_bad", 32'(got.checksum_bad), 32'(want.checksum_bad));
  endtask

  task automatic clear_context();
    ctx_count     = '0;
    ctx_hdr_bytes = '0;
    ctx_sum       = '0;
    ctx_hold      = '0;
    ctx_length    = '0;
    ctx_frag      = '0;
    ctx_proto     = '0;
    ctx_src       = '0;
    ctx_dst       = '0;
    ctx_ports     = '0;
  endtask

  // one accepted byte into the context; on the marked byte, the packet summary
  task automatic absorb_quoted_byte(input in_item_t it, output bit done,
                                    output out_item_t res);
    int         idx;
    int         seen;
    logic [7:0] b;
    logic [7:0] msg_type;
    b    = it.data_byte;
    idx  = int'(ctx_count);
    done = 1'b0;
    res  = NoCheck;

    if (idx == 0) ctx_hdr_bytes = {b[3:0], 2'b00};
    case (idx)
      2: ctx_length[15:8] = b;
      3: ctx_length[7:0]  = b;
      6: ctx_frag[15:8]   = b;
      7: ctx_frag[7:0]    = b;
      9: ctx_proto        = b;
      default: ;
    endcase
    if (idx >= 12 && idx < 16) ctx_src |= 32'(b) << (8 * (15 - idx));
    if (idx >= 16 && idx < 20) ctx_dst |= 32'(b) << (8 * (19 - idx));

    if (idx < ctx_hdr_bytes) begin
      if (idx % 2 == 0) begin
        ctx_hold = b;
      end else begin
        ctx_sum = ctx_sum + {ctx_hold, b};
        // end-around carry
        if (ctx_sum > 17'h0ffff) ctx_sum = ctx_sum[15:0] + 17'd1;
      end
    end else if (idx < ctx_hdr_bytes + 4) begin
      ctx_ports |= 32'(b) << (8 * (3 - (idx - ctx_hdr_bytes)));
    end

    if (ctx_count != CountMax) ctx_count++;
    if (!it.last_byte) return;

    seen = int'(ctx_count);
    done = 1'b1;
    if (ctx_hdr_bytes < 20 || ctx_hdr_bytes > seen) begin
      res.header_length_bad = 1'b1;
    end else begin
      res.source_address  = ctx_src;
      res.dest_address    = ctx_dst;
      res.total_length    = ctx_length;
      res.checksum_bad    = (ctx_sum[15:0] != SUM_GOOD);
      res.fragment_offset = ctx_frag[12:0];
      res.more_fragments  = ctx_frag[13];
      res.dont_fragment   = ctx_frag[14];
      if (ctx_proto == PROTO_NUM_TCP)       res.proto_class = PROTO_TCP;
      else if (ctx_proto == PROTO_NUM_UDP)  res.proto_class = PROTO_UDP;
      else if (ctx_proto == PROTO_NUM_ICMP) res.proto_class = PROTO_ICMP;
      if (seen < ctx_hdr_bytes + 4) begin
        res.header_length_bad = 1'b1;
      end else if (res.proto_class == PROTO_TCP || res.proto_class == PROTO_UDP) begin
        res.source_port = ctx_ports[31:16];
        res.dest_port   = ctx_ports[15:0];
      end else if (res.proto_class == PROTO_ICMP) begin
        msg_type        = ctx_ports[31:24];
        res.source_port = {8'h00, msg_type};
        // request/reply pairs swap, anything else reports its code
        case (msg_type)
          MSG_ECHO_REQ:   res.dest_port = {8'h00, MSG_ECHO_REP};
          MSG_ECHO_REP:   res.dest_port = {8'h00, MSG_ECHO_REQ};
          MSG_TS_REQ:     res.dest_port = {8'h00, MSG_TS_REP};
          MSG_TS_REP:     res.dest_port = {8'h00, MSG_TS_REQ};
          MSG_INFO_REQ:   res.dest_port = {8'h00, MSG_INFO_REP};
          MSG_INFO_REP:   res.dest_port = {8'h00, MSG_INFO_REQ};
          MSG_ROUTER_SOL: res.dest_port = {8'h00, MSG_ROUTER_ADV};
          MSG_MASK_REQ:   res.dest_port = {8'h00, MSG_MASK_REP};
          MSG_MASK_REP:   res.dest_port = {8'h00, MSG_MASK_REQ};
          default:        res.dest_port = {8'h00, ctx_ports[23:16]};
        endcase
      end
    end
    clear_context();
  endtask

  // drive one byte, wait for it to be taken, then update the bench parser
  task automatic send_byte(input in_item_t it, input bit has_want, input out_item_t want);
    bit        done;
    out_item_t res;
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    absorb_quoted_byte(it, done, res);
    if (done) awaited_results.push_back(has_want ? want : res);
    bytes_sent++;
  endtask

  task automatic send_packet();
    logic [7:0] pkt [200];
    in_item_t   it;
    int         kind;
    int         ihl;
    int         hdr;
    int         n;
    int         sum;
    kind = $urandom_range(99);
    ihl  = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
    if (kind >= 80 && kind < 88) ihl = $urandom_range(4, 0);
    hdr = ihl * 4;

    foreach (pkt[i]) pkt[i] = 8'($urandom);
    pkt[0] = {($urandom_range(7) == 0) ? 4'($urandom) : 4'd4, 4'(ihl)};
    case ($urandom_range(3))
      0: pkt[9] = PROTO_NUM_TCP;
      1: pkt[9] = PROTO_NUM_UDP;
      2: pkt[9] = PROTO_NUM_ICMP;
      default: ;
    endcase
    if (pkt[9] == PROTO_NUM_ICMP && $urandom_range(3) != 0)
      pkt[hdr] = IcmpTypes[$urandom_range(9)];

    // valid header checksum unless this one is meant to be corrupted
    pkt[10] = 8'h00;
    pkt[11] = 8'h00;
    sum = 0;
    for (int i = 0; i < hdr; i += 2) begin
      sum += {pkt[i], pkt[i+1]};
      sum = (sum & 16'hffff) + (sum >> 16);
    end
    pkt[10] = ~sum[15:8];
    pkt[11] = ~sum[7:0];
    if (kind >= 88 && kind < 95) pkt[$urandom_range(hdr - 1)] ^= 8'(1 << $urandom_range(7));

    if (kind >= 70 && kind < 80)      n = $urandom_range(hdr + 3, 1);
    else if (kind >= 80 && kind < 88) n = $urandom_range(40, 1);
    else if (kind >= 95)              n = $urandom_range(160, 100);
    else                              n = hdr + 4 + $urandom_range(8);

    for (int i = 0; i < n; i++) begin
      it.data_byte = pkt[i];
      it.last_byte = (i == n - 1);
      send_byte(it, 1'b0, NoCheck);
    end
    packets_built++;
  endtask

  // result side: check every transaction taken, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited", out_data.source_address, '0);
      end else begin
        oldest_result = awaited_results.pop_front();
        compare_result(out_data, oldest_result);
      end
      results_seen++;
      case (out_data.proto_class)
        PROTO_TCP:  tcp_seen++;
        PROTO_UDP:  udp_seen++;
        PROTO_ICMP: icmp_seen++;
        default: ;
      endcase
      if (out_data.header_length_bad) bad_len_seen++;
      if (out_data.checksum_bad)      bad_sum_seen++;
    end
    out_stall <= (!rst_n || calm) ? 1'b0 : ($urandom_range(99) < 19);
  end

  initial begin
    clear_context();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedRows[i])
      send_byte(DirectedRows[i].item, DirectedRows[i].has_want, DirectedRows[i].want);

    // hold off until the directed results have all drained
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);

    while (bytes_sent < $size(DirectedRows) + RandomBytes) begin
      calm = (packets_built >= 20 && packets_built < 32);
      send_packet();
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d bytes in %0d random packets plus directed rows, %0d results checked",
             bytes_sent, packets_built, results_seen);
    $display("tcp %0d, udp %0d, icmp %0d, bad length %0d, bad checksum %0d, mismatches %0d",
             tcp_seen, udp_seen, icmp_seen, bad_len_seen, bad_sum_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* icmp4_error_context_parser_core.f */
design/icmp4_ctx_pkg.sv
design/icmp4_ctx_capture.sv
design/icmp4_ctx_format.sv
design/icmp4_error_context_parser_core.sv
design/icmp4_ctx_checker.sv
test/tb_top.sv
